// File: src/cursor_array_list_of_pairs_macros.svh
// ----------------------------------------------------------------------------
// cursor_array_list_of_pairs_macros
// assertion macros shared by the list block
// ----------------------------------------------------------------------------
`ifndef CURSOR_ARRAY_LIST_OF_PAIRS_MACROS_SVH
`define CURSOR_ARRAY_LIST_OF_PAIRS_MACROS_SVH

// condition holds at every edge out of reset
`define CALP_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// same-cycle implication
`define CALP_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CALP_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/calp_pkg.sv
// ----------------------------------------------------------------------------
// calp_pkg
// types, widths and codes of the cursor list of pairs
// ----------------------------------------------------------------------------
package calp_pkg;

    localparam int DEPTH  = 32;
    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int REQ_W  = 4;
    localparam int POS_W  = 5;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int SIZE_W = 6;
    localparam int PAIR_W = 2 * DATA_W;

    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [SIZE_W-1:0] size_t;
    typedef logic [STAT_W-1:0] stat_t;
    typedef logic [REQ_W-1:0]  req_t;

    localparam req_t REQ_CLEAR      = 4'd0;
    localparam req_t REQ_FIRST      = 4'd1;
    localparam req_t REQ_PREV       = 4'd2;
    localparam req_t REQ_NEXT       = 4'd3;
    localparam req_t REQ_LAST       = 4'd4;
    localparam req_t REQ_SET_POS    = 4'd5;
    localparam req_t REQ_REPLACE    = 4'd6;
    localparam req_t REQ_ERASE      = 4'd7;
    localparam req_t REQ_INS_AFTER  = 4'd8;
    localparam req_t REQ_INS_BEFORE = 4'd9;

    localparam stat_t ST_DONE    = 2'd0;
    localparam stat_t ST_FULL    = 2'd1;
    localparam stat_t ST_IGNORED = 2'd2;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } pair_t;

    typedef struct packed {
        req_t                     req_type;
        pos_t                     new_position;
        logic signed [DATA_W-1:0] x_value;
        logic signed [DATA_W-1:0] y_value;
    } in_t;

    typedef struct packed {
        stat_t                    status;
        size_t                    list_size;
        pos_t                     cursor;
        logic signed [DATA_W-1:0] cursor_x;
        logic signed [DATA_W-1:0] cursor_y;
    } out_t;

endpackage

// File: src/calp_ram.sv
// ----------------------------------------------------------------------------
// calp_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module calp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             re,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/cursor_array_list_of_pairs.sv
// ----------------------------------------------------------------------------
// cursor_array_list_of_pairs
// clear, moves and replace go from accept straight to the done state, which sets out_valid
// once the output is free; erase and insert first shift n entries (0 to DEPTH - 1) in the shift and finish states
// one request at a time: the next is accepted only after the result beat is set
// reset: list empty, cursor 0, no clearing pass (slots past the end are never read)
// ----------------------------------------------------------------------------
`include "cursor_array_list_of_pairs_macros.svh"

module cursor_array_list_of_pairs (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  calp_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output calp_pkg::out_t  out_data
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_FIN   = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]        state_reg,    state_next;
    calp_pkg::cnt_t    count_reg,    count_next;
    calp_pkg::idx_t    cursor_reg,   cursor_next;
    calp_pkg::cnt_t    rem_reg,      rem_next;
    calp_pkg::idx_t    rd_addr_reg,  rd_addr_next;
    calp_pkg::idx_t    wr_addr_reg,  wr_addr_next;
    logic              pend_reg,     pend_next;
    logic              ins_reg,      ins_next;
    calp_pkg::idx_t    slot_reg,     slot_next;
    calp_pkg::pair_t   pair_reg,     pair_next;
    calp_pkg::stat_t   status_reg,   status_next;
    logic              use_rd_reg,   use_rd_next;
    logic              out_valid_reg, out_valid_next;
    calp_pkg::out_t    out_reg,      out_next;

    logic              mem_we;
    calp_pkg::idx_t    mem_waddr;
    calp_pkg::pair_t   mem_wdata;
    logic              mem_re;
    calp_pkg::idx_t    mem_raddr;
    calp_pkg::pair_t   mem_rdata;

    logic              out_free;
    logic              rd_now;
    calp_pkg::cnt_t    cnt_m1;
    calp_pkg::cnt_t    slot_cnt;
    calp_pkg::pair_t   in_pair;

    calp_ram #(
        .WIDTH (calp_pkg::PAIR_W),
        .DEPTH (calp_pkg::DEPTH)
    ) u_ram (
        .clk     (clk),
        .we      (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .re      (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    assign out_free  = !out_valid_reg || out_ready;
    assign cnt_m1    = count_reg - calp_pkg::cnt_t'(1);
    assign in_pair   = '{x: in_data.x_value, y: in_data.y_value};
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        rem_next       = rem_reg;
        rd_addr_next   = rd_addr_reg;
        wr_addr_next   = wr_addr_reg;
        pend_next      = pend_reg;
        ins_next       = ins_reg;
        slot_next      = slot_reg;
        pair_next      = pair_reg;
        status_next    = status_reg;
        use_rd_next    = use_rd_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        mem_we         = 1'b0;
        mem_waddr      = wr_addr_reg;
        mem_wdata      = mem_rdata;
        mem_re         = 1'b0;
        mem_raddr      = cursor_reg;
        rd_now         = 1'b0;
        slot_cnt       = '0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pair_next   = in_pair;
                    status_next = calp_pkg::ST_DONE;
                    use_rd_next = 1'b1;
                    state_next  = S_DONE;
                    case (in_data.req_type)
                        calp_pkg::REQ_CLEAR:
                        begin
                            count_next  = '0;
                            cursor_next = '0;
                        end
                        calp_pkg::REQ_FIRST:
                        begin
                            cursor_next = '0;
                            rd_now      = 1'b1;
                        end
                        calp_pkg::REQ_PREV:
                        begin
                            if (cursor_reg != '0)
                            begin
                                cursor_next = cursor_reg - calp_pkg::idx_t'(1);
                            end
                            rd_now = 1'b1;
                        end
                        calp_pkg::REQ_NEXT:
                        begin
                            if (count_reg != '0 && calp_pkg::cnt_t'(cursor_reg) < cnt_m1)
                            begin
                                cursor_next = cursor_reg + calp_pkg::idx_t'(1);
                            end
                            rd_now = 1'b1;
                        end
                        calp_pkg::REQ_LAST:
                        begin
                            cursor_next = (count_reg != '0) ? calp_pkg::idx_t'(cnt_m1) : '0;
                            rd_now      = 1'b1;
                        end
                        calp_pkg::REQ_SET_POS:
                        begin
                            if (calp_pkg::cnt_t'(in_data.new_position) < count_reg)
                            begin
                                cursor_next = calp_pkg::idx_t'(in_data.new_position);
                            end
                            else
                            begin
                                status_next = calp_pkg::ST_IGNORED;
                            end
                            rd_now = 1'b1;
                        end
                        calp_pkg::REQ_REPLACE:
                        begin
                            use_rd_next = 1'b0;
                            if (count_reg != '0)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = cursor_reg;
                                mem_wdata = in_pair;
                            end
                            else
                            begin
                                status_next = calp_pkg::ST_IGNORED;
                            end
                        end
                        calp_pkg::REQ_ERASE:
                        begin
                            if (count_reg != '0)
                            begin
                                ins_next     = 1'b0;
                                rem_next     = cnt_m1 - calp_pkg::cnt_t'(cursor_reg);
                                rd_addr_next = cursor_reg + calp_pkg::idx_t'(1);
                                pend_next    = 1'b0;
                                state_next   = S_SHIFT;
                            end
                            else
                            begin
                                status_next = calp_pkg::ST_IGNORED;
                            end
                        end
                        calp_pkg::REQ_INS_AFTER,
                        calp_pkg::REQ_INS_BEFORE:
                        begin
                            if (count_reg == calp_pkg::cnt_t'(calp_pkg::DEPTH))
                            begin
                                status_next = calp_pkg::ST_FULL;
                                rd_now      = 1'b1;
                            end
                            else
                            begin
                                if (count_reg == '0)
                                begin
                                    slot_cnt = '0;
                                end
                                else if (in_data.req_type == calp_pkg::REQ_INS_AFTER)
                                begin
                                    slot_cnt = calp_pkg::cnt_t'(cursor_reg)
                                        + calp_pkg::cnt_t'(1);
                                end
                                else
                                begin
                                    slot_cnt = calp_pkg::cnt_t'(cursor_reg);
                                end
                                ins_next     = 1'b1;
                                rem_next     = count_reg - slot_cnt;
                                rd_addr_next = calp_pkg::idx_t'(cnt_m1);
                                slot_next    = calp_pkg::idx_t'(slot_cnt);
                                pend_next    = 1'b0;
                                state_next   = S_SHIFT;
                            end
                        end
                        default:
                        begin
                            status_next = calp_pkg::ST_IGNORED;
                            rd_now      = 1'b1;
                        end
                    endcase
                    if (rd_now)
                    begin
                        mem_re    = 1'b1;
                        mem_raddr = cursor_next;
                    end
                end
            end
            S_SHIFT:
            begin
                // retire the move read last cycle, issue the next read
                mem_we    = pend_reg;
                mem_waddr = wr_addr_reg;
                mem_wdata = mem_rdata;
                if (rem_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = rd_addr_reg;
                    if (ins_reg)
                    begin
                        wr_addr_next = rd_addr_reg + calp_pkg::idx_t'(1);
                        rd_addr_next = rd_addr_reg - calp_pkg::idx_t'(1);
                    end
                    else
                    begin
                        wr_addr_next = rd_addr_reg - calp_pkg::idx_t'(1);
                        rd_addr_next = rd_addr_reg + calp_pkg::idx_t'(1);
                    end
                    rem_next  = rem_reg - calp_pkg::cnt_t'(1);
                    pend_next = 1'b1;
                end
                else
                begin
                    pend_next  = 1'b0;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (ins_reg)
                begin
                    mem_we      = 1'b1;
                    mem_waddr   = slot_reg;
                    mem_wdata   = pair_reg;
                    cursor_next = slot_reg;
                    count_next  = count_reg + calp_pkg::cnt_t'(1);
                    use_rd_next = 1'b0;
                end
                else
                begin
                    count_next = cnt_m1;
                    if (cnt_m1 == '0)
                    begin
                        cursor_next = '0;
                    end
                    else if (calp_pkg::cnt_t'(cursor_reg) >= cnt_m1)
                    begin
                        cursor_next = calp_pkg::idx_t'(cnt_m1 - calp_pkg::cnt_t'(1));
                    end
                    mem_re      = 1'b1;
                    mem_raddr   = cursor_next;
                    use_rd_next = 1'b1;
                end
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next     = 1'b1;
                    out_next.status    = status_reg;
                    out_next.list_size = calp_pkg::size_t'(count_reg);
                    out_next.cursor    = calp_pkg::pos_t'(cursor_reg);
                    if (count_reg == '0)
                    begin
                        out_next.cursor_x = '0;
                        out_next.cursor_y = '0;
                    end
                    else if (use_rd_reg)
                    begin
                        out_next.cursor_x = mem_rdata.x;
                        out_next.cursor_y = mem_rdata.y;
                    end
                    else
                    begin
                        out_next.cursor_x = pair_reg.x;
                        out_next.cursor_y = pair_reg.y;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            ins_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            ins_reg       <= ins_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= rd_addr_next;
        wr_addr_reg <= wr_addr_next;
        slot_reg    <= slot_next;
        pair_reg    <= pair_next;
        status_reg  <= status_next;
        use_rd_reg  <= use_rd_next;
        out_reg     <= out_next;
    end

    `CALP_HOLDS(a_count_bound, count_reg <= calp_pkg::cnt_t'(calp_pkg::DEPTH), "count above depth")
    `CALP_IMPL(a_cursor_in_list, count_reg != '0, calp_pkg::cnt_t'(cursor_reg) < count_reg, "cursor past last entry")
    `CALP_NEXT(a_shift_progress, state_reg == S_SHIFT && rem_reg != '0, rem_reg == $past(rem_reg) - calp_pkg::cnt_t'(1), "shift count did not step")
    `CALP_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second beat taken during a request")
    `CALP_IMPL(a_empty_zero, out_valid_reg && out_reg.list_size == '0, out_reg.cursor_x == '0 && out_reg.cursor_y == '0 && out_reg.cursor == '0, "empty list beat not zero")

endmodule

// File: test/cursor_array_list_of_pairs_tb.sv
// ----------------------------------------------------------------------------
// cursor_array_list_of_pairs_tb
// self-checking bench for the cursor list of (x,y) pairs
//
// A table of opening requests walks the empty list, the signed extremes, the
// edges of navigation, out-of-range positions and unknown codes, with the
// result typed in where it is obvious. Random segments follow that build,
// edit, tear down, fill the list to capacity so that inserts are turned
// away, or mix in noise. A list model predicts every beat. The sender runs
// in bursts and the receiver stalls, twice long enough to back up the block.
// ----------------------------------------------------------------------------
module cursor_array_list_of_pairs_tb;

    localparam int             N_RANDOM      = 1325;
    localparam int             LIMIT_CYCLES  = 1_000_000;
    localparam int             TAIL_CYCLES   = 40;
    localparam int             LONG_HOLD     = 400;
    localparam calp_pkg::req_t REQ_UNUSED_LO = 4'd10;
    localparam calp_pkg::req_t REQ_UNUSED_HI = 4'd15;

    typedef enum int {SEG_BUILD, SEG_EDIT, SEG_TEAR, SEG_FILL, SEG_NOISE} segment_t;

    typedef struct packed {
        calp_pkg::in_t  item;
        logic           fixed;
        calp_pkg::out_t result;
    } opening_row_t;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    calp_pkg::in_t  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    calp_pkg::out_t out_data;

    // list model
    logic signed [calp_pkg::DATA_W-1:0] list_x [calp_pkg::DEPTH] = '{default: '0};
    logic signed [calp_pkg::DATA_W-1:0] list_y [calp_pkg::DEPTH] = '{default: '0};
    int list_count  = 0;
    int list_cursor = 0;

    calp_pkg::out_t pending_results [$];
    int   mismatches    = 0;
    int   beats_seen    = 0;
    int   burst_left    = 0;
    int   hold_trigger  = 0;

    opening_row_t opening_rows [25] = '{
        '{'{calp_pkg::REQ_ERASE,      5'd0,  32'h0,         32'h0},         1'b1,
          '{calp_pkg::ST_IGNORED, 6'd0, 5'd0, 32'h0, 32'h0}},
        '{'{calp_pkg::REQ_REPLACE,    5'd0,  32'h7fff_ffff, 32'h8000_0000}, 1'b1,
          '{calp_pkg::ST_IGNORED, 6'd0, 5'd0, 32'h0, 32'h0}},
        '{'{calp_pkg::REQ_LAST,       5'd0,  32'h0,         32'h0},         1'b1,
          '{calp_pkg::ST_DONE, 6'd0, 5'd0, 32'h0, 32'h0}},
        '{'{calp_pkg::REQ_PREV,       5'd0,  32'h0,         32'h0},         1'b1,
          '{calp_pkg::ST_DONE, 6'd0, 5'd0, 32'h0, 32'h0}},
        '{'{calp_pkg::REQ_NEXT,       5'd0,  32'h0,         32'h0},         1'b1,
          '{calp_pkg::ST_DONE, 6'd0, 5'd0, 32'h0, 32'h0}},
        '{'{calp_pkg::REQ_SET_POS,    5'd31, 32'h0,         32'h0},         1'b1,
          '{calp_pkg::ST_IGNORED, 6'd0, 5'd0, 32'h0, 32'h0}},
        '{'{calp_pkg::REQ_INS_AFTER,  5'd0,  32'h7fff_ffff, 32'h8000_0000}, 1'b1,
          '{calp_pkg::ST_DONE, 6'd1, 5'd0, 32'h7fff_ffff, 32'h8000_0000}},
        '{'{calp_pkg::REQ_INS_BEFORE, 5'd0,  32'h8000_0000, 32'h7fff_ffff}, 1'b1,
          '{calp_pkg::ST_DONE, 6'd2, 5'd0, 32'h8000_0000, 32'h7fff_ffff}},
        '{'{calp_pkg::REQ_INS_AFTER,  5'd0,  32'hffff_ffff, 32'h0},         1'b1,
          '{calp_pkg::ST_DONE, 6'd3, 5'd1, 32'hffff_ffff, 32'h0}},
        '{'{calp_pkg::REQ_SET_POS,    5'd31, 32'h0,         32'h0},         1'b1,
          '{calp_pkg::ST_IGNORED, 6'd3, 5'd1, 32'hffff_ffff, 32'h0}},
        '{'{calp_pkg::REQ_NEXT,       5'd0,  32'h0,         32'h0},         1'b0, '0},
        '{'{calp_pkg::REQ_NEXT,       5'd0,  32'h0,         32'h0},         1'b0, '0},
        '{'{calp_pkg::REQ_FIRST,      5'd0,  32'h0,         32'h0},         1'b0, '0},
        '{'{calp_pkg::REQ_PREV,       5'd0,  32'h0,         32'h0},         1'b0, '0},
        '{'{calp_pkg::REQ_LAST,       5'd0,  32'h0,         32'h0},         1'b0, '0},
        '{'{calp_pkg::REQ_REPLACE,    5'd0,  32'h0,         32'hffff_ffff}, 1'b0, '0},
        '{'{calp_pkg::REQ_ERASE,      5'd0,  32'h0,         32'h0},         1'b0, '0},
        '{'{calp_pkg::REQ_SET_POS,    5'd0,  32'h0,         32'h0},         1'b0, '0},
        '{'{calp_pkg::REQ_INS_BEFORE, 5'd0,  32'h1234_5678, 32'h9abc_def0}, 1'b0, '0},
        '{'{calp_pkg::REQ_ERASE,      5'd0,  32'h0,         32'h0},         1'b0, '0},
        '{'{REQ_UNUSED_LO,            5'd0,  32'h0,         32'h0},         1'b0, '0},
        '{'{REQ_UNUSED_HI,            5'd31, 32'hffff_ffff, 32'hffff_ffff}, 1'b0, '0},
        '{'{calp_pkg::REQ_SET_POS,    5'd1,  32'h0,         32'h0},         1'b0, '0},
        '{'{calp_pkg::REQ_CLEAR,      5'd0,  32'h0,         32'h0},         1'b1,
          '{calp_pkg::ST_DONE, 6'd0, 5'd0, 32'h0, 32'h0}},
        '{'{calp_pkg::REQ_INS_BEFORE, 5'd10, 32'h5a5a_5a5a, 32'ha5a5_a5a5}, 1'b0, '0}
    };

    cursor_array_list_of_pairs DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    always #1 clk = ~clk;

    function automatic calp_pkg::out_t apply_request(calp_pkg::in_t rq);
        calp_pkg::out_t  r;
        calp_pkg::stat_t st;
        int              slot;
        st = calp_pkg::ST_DONE;
        case (rq.req_type)
            calp_pkg::REQ_CLEAR:
            begin
                for (int i = 0; i < calp_pkg::DEPTH; i++)
                begin
                    list_x[i] = '0;
                    list_y[i] = '0;
                end
                list_count  = 0;
                list_cursor = 0;
            end
            calp_pkg::REQ_FIRST: list_cursor = 0;
            calp_pkg::REQ_PREV:
            begin
                if (list_cursor > 0)
                    list_cursor--;
            end
            calp_pkg::REQ_NEXT:
            begin
                if (list_count > 0 && list_cursor < list_count - 1)
                    list_cursor++;
            end
            calp_pkg::REQ_LAST: list_cursor = (list_count > 0) ? list_count - 1 : 0;
            calp_pkg::REQ_SET_POS:
            begin
                if (int'(rq.new_position) < list_count)
                    list_cursor = int'(rq.new_position);
                else
                    st = calp_pkg::ST_IGNORED;
            end
            calp_pkg::REQ_REPLACE:
            begin
                if (list_count > 0)
                begin
                    list_x[list_cursor] = rq.x_value;
                    list_y[list_cursor] = rq.y_value;
                end
                else
                    st = calp_pkg::ST_IGNORED;
            end
            calp_pkg::REQ_ERASE:
            begin
                if (list_count > 0)
                begin
                    for (int i = list_cursor; i + 1 < list_count; i++)
                    begin
                        list_x[i] = list_x[i+1];
                        list_y[i] = list_y[i+1];
                    end
                    list_x[list_count-1] = '0;
                    list_y[list_count-1] = '0;
                    list_count--;
                    if (list_count == 0)
                        list_cursor = 0;
                    else if (list_cursor >= list_count)
                        list_cursor = list_count - 1;
                end
                else
                    st = calp_pkg::ST_IGNORED;
            end
            calp_pkg::REQ_INS_AFTER, calp_pkg::REQ_INS_BEFORE:
            begin
                if (list_count >= calp_pkg::DEPTH)
                    st = calp_pkg::ST_FULL;
                else
                begin
                    if (list_count == 0)
                        slot = 0;
                    else if (rq.req_type == calp_pkg::REQ_INS_AFTER)
                        slot = list_cursor + 1;
                    else
                        slot = list_cursor;
                    for (int i = list_count; i > slot; i--)
                    begin
                        list_x[i] = list_x[i-1];
                        list_y[i] = list_y[i-1];
                    end
                    list_x[slot] = rq.x_value;
                    list_y[slot] = rq.y_value;
                    list_cursor  = slot;
                    list_count++;
                end
            end
            default: st = calp_pkg::ST_IGNORED;
        endcase
        r.status    = st;
        r.list_size = calp_pkg::size_t'(list_count);
        r.cursor    = calp_pkg::pos_t'(list_cursor);
        r.cursor_x  = (list_count > 0) ? list_x[list_cursor] : '0;
        r.cursor_y  = (list_count > 0) ? list_y[list_cursor] : '0;
        return r;
    endfunction

    function automatic logic [calp_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic calp_pkg::in_t gen_request(segment_t kind);
        calp_pkg::in_t  rq;
        int             r;
        calp_pkg::req_t ins_req;
        calp_pkg::req_t nav_req;
        r            = $urandom_range(0, 99);
        ins_req      = $urandom_range(0, 1) ? calp_pkg::REQ_INS_AFTER
                                            : calp_pkg::REQ_INS_BEFORE;
        nav_req      = calp_pkg::req_t'($urandom_range(calp_pkg::REQ_FIRST,
                                                       calp_pkg::REQ_LAST));
        rq.x_value   = pick_value();
        rq.y_value   = pick_value();
        rq.new_position = calp_pkg::pos_t'($urandom_range(0, 31));
        case (kind)
            SEG_BUILD:
                rq.req_type = (r < 55) ? ins_req : (r < 80) ? nav_req :
                              (r < 88) ? calp_pkg::REQ_SET_POS :
                              (r < 95) ? calp_pkg::REQ_REPLACE : calp_pkg::REQ_ERASE;
            SEG_EDIT:
                rq.req_type = (r < 20) ? ins_req : (r < 45) ? nav_req :
                              (r < 60) ? calp_pkg::REQ_SET_POS :
                              (r < 80) ? calp_pkg::REQ_REPLACE : calp_pkg::REQ_ERASE;
            SEG_TEAR:
                rq.req_type = (r < 60) ? calp_pkg::REQ_ERASE : (r < 80) ? nav_req :
                              (r < 90) ? calp_pkg::REQ_SET_POS : calp_pkg::REQ_REPLACE;
            SEG_FILL:
                rq.req_type = ins_req;
            default:
                rq.req_type = (r < 30) ?
                              calp_pkg::req_t'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)) :
                              (r < 45) ? calp_pkg::REQ_CLEAR :
                              calp_pkg::req_t'($urandom_range(0, 15));
        endcase
        // mostly aim set position at an existing entry
        if (rq.req_type == calp_pkg::REQ_SET_POS && list_count > 0
            && $urandom_range(0, 3) != 0)
            rq.new_position = calp_pkg::pos_t'($urandom_range(0, list_count - 1));
        return rq;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("ERROR beat %0d %s: got %h expected %h", beats_seen, what, got, want);
        mismatches++;
    endtask

    task automatic send_beat(calp_pkg::in_t item, logic fixed, calp_pkg::out_t fixed_result);
        calp_pkg::out_t want;
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
        want = apply_request(item);
        if (fixed)
            want = fixed_result;
        pending_results.push_back(want);
    endtask

    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // receiver: changing stall pattern plus one long hold per trigger
    always @(posedge clk)
    begin : receiver
        static int rx_cycle  = 0;
        static int rx_mode   = 0;
        static int hold_left = 0;
        static int hold_seen = 0;
        rx_cycle++;
        if (hold_seen != hold_trigger)
        begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
        end
        if (rx_cycle % 50 == 0)
            rx_mode = $urandom_range(0, 3);
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            case (rx_mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= $urandom_range(0, 1);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((rx_cycle / 5) % 3 != 0);
            endcase
    end

    always @(posedge clk)
    begin : result_check
        calp_pkg::out_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("beat with nothing pending", 64'(out_data.status), '0);
            else
            begin
                want = pending_results.pop_front();
                if (out_data.status !== want.status)
                    report_mismatch("status", 64'(out_data.status), 64'(want.status));
                if (out_data.list_size !== want.list_size)
                    report_mismatch("list_size", 64'(out_data.list_size), 64'(want.list_size));
                if (out_data.cursor !== want.cursor)
                    report_mismatch("cursor", 64'(out_data.cursor), 64'(want.cursor));
                if (out_data.cursor_x !== want.cursor_x)
                    report_mismatch("cursor_x", 64'(out_data.cursor_x), 64'(want.cursor_x));
                if (out_data.cursor_y !== want.cursor_y)
                    report_mismatch("cursor_y", 64'(out_data.cursor_y), 64'(want.cursor_y));
            end
            beats_seen++;
        end
    end

    initial
    begin
        #(2 * LIMIT_CYCLES);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin : stimulus
        segment_t kind;
        int       seg_len;
        int       random_sent;
        int       r;
        random_sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
        begin
            send_beat(opening_rows[i].item, opening_rows[i].fixed, opening_rows[i].result);
            pace();
        end

        while (random_sent < N_RANDOM)
        begin
            r = $urandom_range(0, 99);
            kind = (r < 25) ? SEG_BUILD : (r < 60) ? SEG_EDIT : (r < 78) ? SEG_TEAR :
                   (r < 92) ? SEG_FILL : SEG_NOISE;
            seg_len = (kind == SEG_FILL) ? calp_pkg::DEPTH - list_count + $urandom_range(1, 4)
                                         : $urandom_range(8, 40);
            for (int k = 0; k < seg_len && random_sent < N_RANDOM; k++)
            begin
                send_beat(gen_request(kind), 1'b0, '0);
                random_sent++;
                if (random_sent == 300 || random_sent == 1000)
                    hold_trigger <= hold_trigger + 1;
                // sender pause until the block has drained
                if (random_sent == 650)
                begin
                    in_valid <= 1'b0;
                    do @(posedge clk); while (pending_results.size() != 0);
                end
                else
                    pace();
            end
        end

        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
